// ===== hw/rtl/dotq_pkg.sv =====
// Package for the deadline ordered task queue: widths, event codes,
// the entry word layout and the aging function.
// No dependencies.
`default_nettype none
package dotq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int TL_W      = 25;
  localparam int INS_W     = 20;
  localparam int ID_W      = 16;
  localparam int BUD_W     = 24;
  localparam int SRV_W     = 4;
  localparam int LIM_W     = 5;
  localparam int LIM_RST   = 16;
  localparam int ENTRY_W   = TL_W + INS_W + ID_W;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [2:0] {
    EV_ACCEPT   = 3'd0,
    EV_REJECT   = 3'd1,
    EV_EXPIRED  = 3'd2,
    EV_SENT     = 3'd3,
    EV_DROPPED  = 3'd4,
    EV_EMPTY    = 3'd5
  } ev_t;

  // one result word, minus the last flag
  typedef struct packed {
    ev_t                     ev;
    logic [ID_W-1:0]         id;
    logic [INS_W-1:0]        ins;
    logic signed [TL_W-1:0]  tl;
    logic [SRV_W-1:0]        srv;
  } res_t;

  // remaining time after elapsed seconds, saturating at -2^24
  function automatic logic signed [TL_W-1:0] aged(input logic signed [TL_W-1:0] tl,
                                                  input logic [31:0] elapsed);
    logic signed [41:0] v;
    v = 42'(tl) - $signed({2'b00, elapsed, 8'h00});
    if (v < -42'sd16777216) aged = -25'sd16777216;
    else aged = v[TL_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dotq_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module dotq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/deadline_ordered_task_queue.sv =====
// Top level of the deadline ordered task queue.
// Depends on dotq_pkg and dotq_ram.
`default_nettype none
// The queue holds up to min(queue_limit, QUEUE_DEPTH) tasks in one RAM used as
// a ring, sorted by remaining time; all held tasks share one time stamp. One
// input word is handled at a time. A dispatch reads the head and then emits its
// result; a rejected insert or an empty dispatch goes straight to its result. An
// accepted insert first reads expired tasks off the head (one result word each),
// then walks the rest from the tail, aging each in place or shifting it up one
// slot to open the gap for the new task, which is written in a state of its own.
// RAM reads are registered. Results leave through an output register; a stalled
// output holds the expiry reads and the last word, but not the tail walk.
module deadline_ordered_task_queue #(
  parameter int QUEUE_DEPTH = dotq_pkg::DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // tdata: now_time[31:0], instruction_count[51:32], time_budget[75:52],
  //        server_ready[76], server_pick[80:77], zero pad
  input  wire logic [dotq_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                            in_tuser,   // mode
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // tdata: task_id[15:0], task_instructions[35:16], time_left[60:36],
  //        server_sent[64:61], zero pad
  output logic [dotq_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [2:0]                           out_tuser,  // event_res
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [dotq_pkg::LIM_W-1:0]      cfg_data,   // queue_limit
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready
);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = (OW > dotq_pkg::LIM_W) ? OW : dotq_pkg::LIM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_B_RD, S_B_CHK, S_B_NEW, S_D_RD, S_D_CHK, S_FLUSH
  } state_t;

  state_t                         state_r;
  logic [dotq_pkg::LIM_W-1:0]     limit_r;
  logic [OW-1:0]                  occ_r, cnt_r;
  logic [AW-1:0]                  head_r;
  logic [31:0]                    stamp_r, now_r, elapsed_r;
  logic [dotq_pkg::ID_W-1:0]      next_id_r, new_id_r;
  logic [dotq_pkg::INS_W-1:0]     ins_r;
  logic [dotq_pkg::BUD_W-1:0]     bud_r;
  logic                           ready_r, placed_r;
  logic [dotq_pkg::SRV_W-1:0]     pick_r;
  dotq_pkg::res_t                 pend_r, out_r;
  logic                           out_valid_r, out_last_r;

  // ring index arithmetic
  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] t;
    t = (s >= (AW+1)'(QUEUE_DEPTH)) ? s - (AW+1)'(QUEUE_DEPTH) : s;
    return t[AW-1:0];
  endfunction

  logic [AW-1:0] slot_hi, slot_lo;
  assign slot_hi = wrap({1'b0, head_r} + (AW+1)'(cnt_r));
  assign slot_lo = wrap({1'b0, head_r} + (AW+1)'(cnt_r) - (AW+1)'(1));

  // B walk reads at the low slot; head port shared by A and D reads
  logic [AW-1:0] raddr;
  assign raddr = (state_r == S_B_RD) ? slot_lo : head_r;

  // RAM and the fields of the word it returns
  logic                            ram_we, ram_re;
  logic [AW-1:0]                   ram_waddr;
  logic [dotq_pkg::ENTRY_W-1:0]    ram_wdata, ram_rdata, new_word;
  logic signed [dotq_pkg::TL_W-1:0] rd_aged, bud_s;
  logic [dotq_pkg::INS_W-1:0]      rd_ins;
  logic [dotq_pkg::ID_W-1:0]       rd_id;

  dotq_ram #(.WIDTH(dotq_pkg::ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(raddr), .rdata(ram_rdata)
  );

  assign rd_aged  = dotq_pkg::aged(ram_rdata[dotq_pkg::ENTRY_W-1 -: dotq_pkg::TL_W], elapsed_r);
  assign rd_ins   = ram_rdata[dotq_pkg::ID_W +: dotq_pkg::INS_W];
  assign rd_id    = ram_rdata[dotq_pkg::ID_W-1:0];
  assign bud_s    = $signed({1'b0, bud_r});
  assign new_word = {bud_s, ins_r, new_id_r};

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = slot_lo;
    ram_wdata = {rd_aged, rd_ins, rd_id};
    unique case (state_r)
      S_A_RD, S_D_RD: ram_re = 1'b1;
      S_B_RD: begin
        if (cnt_r == '0) begin
          ram_we    = !placed_r;
          ram_waddr = head_r;
          ram_wdata = new_word;
        end else begin
          ram_re = 1'b1;
        end
      end
      S_B_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = (!placed_r && rd_aged > bud_s) ? slot_hi : slot_lo;
      end
      S_B_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = slot_hi;
        ram_wdata = new_word;
      end
      default: ;
    endcase
  end

  logic can_emit, full, emit_now;
  logic [CW-1:0] lim;
  assign can_emit  = !out_valid_r || out_tready;
  assign emit_now  = can_emit && ((state_r == S_A_CHK && rd_aged < 0) || state_r == S_FLUSH);
  assign lim       = (CW'(limit_r) > CW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(limit_r);
  assign full      = CW'(occ_r) >= lim;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= dotq_pkg::LIM_W'(dotq_pkg::LIM_RST);
      occ_r       <= '0;
      head_r      <= '0;
      next_id_r   <= dotq_pkg::ID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) limit_r <= cfg_data;
      out_valid_r <= emit_now || (out_valid_r && !out_tready);
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            now_r     <= in_tdata[31:0];
            ins_r     <= in_tdata[51:32];
            bud_r     <= in_tdata[75:52];
            ready_r   <= in_tdata[76];
            pick_r    <= in_tdata[80:77];
            elapsed_r <= (in_tdata[31:0] >= stamp_r) ? in_tdata[31:0] - stamp_r : '0;
            placed_r  <= 1'b0;
            if (in_tuser) begin
              if (occ_r == '0) begin
                pend_r  <= '{ev: dotq_pkg::EV_EMPTY, id: '0, ins: '0, tl: '0, srv: '0};
                state_r <= S_FLUSH;
              end else begin
                state_r <= S_D_RD;
              end
            end else if (full) begin
              pend_r  <= '{ev: dotq_pkg::EV_REJECT, id: '0, ins: in_tdata[51:32],
                           tl: $signed({1'b0, in_tdata[75:52]}), srv: '0};
              state_r <= S_FLUSH;
            end else begin
              pend_r    <= '{ev: dotq_pkg::EV_ACCEPT, id: next_id_r, ins: in_tdata[51:32],
                             tl: $signed({1'b0, in_tdata[75:52]}), srv: '0};
              new_id_r  <= next_id_r;
              next_id_r <= next_id_r + 1'b1;
              state_r   <= S_A_RD;
            end
          end
        end
        // drop expired tasks off the head, in queue order
        S_A_RD: begin
          if (occ_r == '0) begin
            cnt_r   <= '0;
            state_r <= S_B_RD;
          end else begin
            state_r <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (rd_aged < 0) begin
            if (can_emit) begin
              out_r       <= pend_r;
              out_last_r  <= 1'b0;
              pend_r      <= '{ev: dotq_pkg::EV_EXPIRED, id: rd_id, ins: rd_ins,
                               tl: rd_aged, srv: '0};
              head_r      <= wrap({1'b0, head_r} + (AW+1)'(1));
              occ_r       <= occ_r - 1'b1;
              state_r     <= S_A_RD;
            end
          end else begin
            cnt_r   <= occ_r;
            state_r <= S_B_RD;
          end
        end
        // walk from the tail: age in place or shift up past the new task
        S_B_RD: begin
          if (cnt_r == '0) begin
            occ_r   <= occ_r + 1'b1;
            stamp_r <= now_r;
            state_r <= S_FLUSH;
          end else begin
            state_r <= S_B_CHK;
          end
        end
        S_B_CHK: begin
          if (!placed_r && !(rd_aged > bud_s)) begin
            state_r <= S_B_NEW;
          end else begin
            cnt_r   <= cnt_r - 1'b1;
            state_r <= S_B_RD;
          end
        end
        S_B_NEW: begin
          placed_r <= 1'b1;
          cnt_r    <= cnt_r - 1'b1;
          state_r  <= S_B_RD;
        end
        // dispatch the head
        S_D_RD: state_r <= S_D_CHK;
        S_D_CHK: begin
          if (rd_aged >= 0 && ready_r)
            pend_r <= '{ev: dotq_pkg::EV_SENT, id: rd_id, ins: rd_ins, tl: rd_aged, srv: pick_r};
          else
            pend_r <= '{ev: dotq_pkg::EV_DROPPED, id: rd_id, ins: rd_ins, tl: rd_aged, srv: '0};
          head_r  <= wrap({1'b0, head_r} + (AW+1)'(1));
          occ_r   <= occ_r - 1'b1;
          state_r <= S_FLUSH;
        end
        S_FLUSH: begin
          if (can_emit) begin
            out_r       <= pend_r;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_r.ev;
  assign out_tdata  = {7'b0, out_r.srv, out_r.tl, out_r.ins, out_r.id};
endmodule
`default_nettype wire

// ===== hw/rtl/dotq_checker.sv =====
// Port level checks for the deadline ordered task queue, bound to the top.
// Depends on dotq_pkg and deadline_ordered_task_queue.
`default_nettype none
module dotq_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [dotq_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic [2:0]                       out_tuser,
  input wire logic                             out_tlast,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready
);
  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // one input word at a time
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // no new input while an item's results are still coming
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in mid burst");

  // empty result is a lone, all-zero word
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == dotq_pkg::EV_EMPTY |-> out_tlast && out_tdata == '0)
    else $error("malformed empty result");
endmodule

bind deadline_ordered_task_queue dotq_checker u_dotq_checker (.*);
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for the deadline ordered task queue: a predictor of the
// sorted queue, a stream driver and monitor with random idling.
// Depends on dotq_pkg and the deadline_ordered_task_queue RTL.
`default_nettype none
module tb_top;

  localparam int DEPTH   = 16;
  localparam int LIMIT_CY = 2000000;

  typedef struct packed {
    logic        mode;
    logic [31:0] now;
    logic [19:0] ins;
    logic [23:0] bud;
    logic        rdy;
    logic [3:0]  pick;
  } task_word_t;

  typedef struct packed {
    dotq_pkg::res_t r;
    logic lst;
  } exp_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [dotq_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0, in_tvalid = 1'b0, out_tready = 1'b0;
  logic in_tready, out_tlast, out_tvalid, cfg_ready;
  logic [dotq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [2:0] out_tuser;
  logic [dotq_pkg::LIM_W-1:0] cfg_data = '0;
  logic cfg_valid = 1'b0;
  logic in_acc = 1'b0;

  always #5 clk = ~clk;

  deadline_ordered_task_queue #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
  );

  // predictor state
  logic signed [24:0] q_tl [DEPTH];
  logic [31:0] q_stamp [DEPTH];
  logic [19:0] q_ins [DEPTH];
  logic [15:0] q_id [DEPTH];
  int unsigned q_occ = 0;
  logic [15:0] id_next = 16'd1;
  logic [4:0] lim_reg = 5'(dotq_pkg::LIM_RST);

  task_word_t pending_q[$];
  exp_word_t  results_q[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;    // no idling in the closing part
  bit hold_tx = 1'b0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic logic signed [24:0] age_entry(input int i, input logic [31:0] now);
    longint e, v;
    e = (now >= q_stamp[i]) ? longint'(now - q_stamp[i]) : 0;
    v = longint'(q_tl[i]) - e * 256;
    if (v < -16777216) v = -16777216;
    return 25'(v);
  endfunction

  function automatic exp_word_t mk(input dotq_pkg::ev_t ev, input logic [15:0] id,
                                   input logic [19:0] ins, input logic signed [24:0] tl,
                                   input logic [3:0] srv, input logic lst);
    exp_word_t x;
    x.r.ev = ev; x.r.id = id; x.r.ins = ins; x.r.tl = tl; x.r.srv = srv; x.lst = lst;
    return x;
  endfunction

  // expected results of one accepted word
  task automatic predict_queue(input task_word_t t);
    int unsigned lim, w;
    logic signed [24:0] v, kt;
    logic [31:0] ks;
    logic [19:0] ki;
    logic [15:0] kid;
    int j;
    exp_word_t batch[$];
    if (t.mode == 1'b0) begin
      lim = (lim_reg > DEPTH) ? DEPTH : lim_reg;
      if (q_occ >= lim) begin
        results_q.push_back(mk(dotq_pkg::EV_REJECT, 16'd0, t.ins, $signed({1'b0, t.bud}),
                               4'd0, 1'b1));
        return;
      end
      q_tl[q_occ] = $signed({1'b0, t.bud}); q_stamp[q_occ] = t.now;
      q_ins[q_occ] = t.ins; q_id[q_occ] = id_next;
      q_occ++;
      batch.push_back(mk(dotq_pkg::EV_ACCEPT, id_next, t.ins, $signed({1'b0, t.bud}),
                         4'd0, 1'b0));
      id_next = id_next + 16'd1;
      w = 0;
      for (int i = 0; i < q_occ; i++) begin
        v = age_entry(i, t.now);
        if (v < 0) begin
          batch.push_back(mk(dotq_pkg::EV_EXPIRED, q_id[i], q_ins[i], v, 4'd0, 1'b0));
        end else begin
          q_tl[w] = v; q_stamp[w] = t.now; q_ins[w] = q_ins[i]; q_id[w] = q_id[i];
          w++;
        end
      end
      q_occ = w;
      for (int i = 1; i < q_occ; i++) begin
        kt = q_tl[i]; ks = q_stamp[i]; ki = q_ins[i]; kid = q_id[i];
        j = i;
        while (j > 0 && q_tl[j-1] > kt) begin
          q_tl[j] = q_tl[j-1]; q_stamp[j] = q_stamp[j-1];
          q_ins[j] = q_ins[j-1]; q_id[j] = q_id[j-1];
          j--;
        end
        q_tl[j] = kt; q_stamp[j] = ks; q_ins[j] = ki; q_id[j] = kid;
      end
      batch[batch.size()-1].lst = 1'b1;
      foreach (batch[k]) results_q.push_back(batch[k]);
    end else if (q_occ == 0) begin
      results_q.push_back(mk(dotq_pkg::EV_EMPTY, 16'd0, 20'd0, 25'sd0, 4'd0, 1'b1));
    end else begin
      v = age_entry(0, t.now);
      if (v >= 0 && t.rdy)
        results_q.push_back(mk(dotq_pkg::EV_SENT, q_id[0], q_ins[0], v, t.pick, 1'b1));
      else
        results_q.push_back(mk(dotq_pkg::EV_DROPPED, q_id[0], q_ins[0], v, 4'd0, 1'b1));
      for (int i = 1; i < q_occ; i++) begin
        q_tl[i-1] = q_tl[i]; q_stamp[i-1] = q_stamp[i];
        q_ins[i-1] = q_ins[i]; q_id[i-1] = q_id[i];
      end
      q_occ--;
    end
  endtask

  // input handshake seen at the last rising edge
  always @(posedge clk) in_acc <= in_tvalid && in_tready;

  // driver: idle bursts, one word per handshake
  int tx_gap = 0;
  always @(negedge clk) begin
    task_word_t t;
    if (rst_n) begin
      if (in_tvalid && !in_acc) begin
        // hold the presented word
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        tx_gap = $urandom_range(1, 18);
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0 && !hold_tx) begin
        t = pending_q.pop_front();
        in_tuser <= t.mode;
        in_tdata <= dotq_pkg::IN_DATA_W'({t.pick, t.rdy, t.bud, t.ins, t.now});
        in_tvalid <= 1'b1;
        predict_queue(t);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  int rx_gap = 0;
  always @(negedge clk) begin
    if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(1, 18);
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    exp_word_t x;
    cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_q.size() == 0) begin
        report($sformatf("unexpected word ev=%0d", out_tuser));
      end else begin
        x = results_q.pop_front();
        if (out_tuser !== x.r.ev) report($sformatf("event %0d exp %0d", out_tuser, x.r.ev));
        if (out_tdata[15:0] !== x.r.id) report($sformatf("id %0h exp %0h", out_tdata[15:0], x.r.id));
        if (out_tdata[35:16] !== x.r.ins) report("instruction count");
        if (out_tdata[60:36] !== x.r.tl)
          report($sformatf("time_left %0h exp %0h", out_tdata[60:36], x.r.tl));
        if (out_tdata[64:61] !== x.r.srv) report("server index");
        if (out_tdata[71:65] !== '0) report("pad bits");
        if (out_tlast !== x.lst) report("last flag");
      end
    end
    if (cycles > LIMIT_CY) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add(input logic m, input logic [31:0] now, input logic [19:0] ins,
                     input logic [23:0] bud, input logic rdy, input logic [3:0] pick);
    task_word_t t;
    t.mode = m; t.now = now; t.ins = ins; t.bud = bud; t.rdy = rdy; t.pick = pick;
    pending_q.push_back(t);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_tvalid || results_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_limit(input logic [4:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    lim_reg = v;
  endtask

  logic [31:0] clock_now;
  int phase_limits[5] = '{16, 1, 31, 4, 0};

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: empty dispatch, extremes, expiry, ties, backward time
    add(1, 0, 0, 0, 1, 4'hF);
    add(0, 100, 20'hFFFFF, 24'hFFFFFF, 0, 0);
    add(0, 100, 0, 0, 0, 0);
    add(0, 100, 5, 24'h000200, 1, 4'hA);
    add(0, 100, 6, 24'h000200, 0, 0);
    add(0, 101, 7, 24'h000300, 0, 0);   // ages others, 0-budget entry expires
    add(0, 50, 8, 24'h000100, 0, 0);    // time runs backward
    add(1, 102, 0, 0, 1, 4'h5);
    add(1, 200, 0, 0, 1, 4'h3);         // dropped late
    add(1, 200, 0, 0, 0, 4'h7);
    add(0, 32'hFFFFFFFF, 1, 24'h000001, 0, 0); // huge elapsed, saturates
    add(1, 32'hFFFFFFFF, 0, 0, 1, 4'h9);
    add(1, 32'hFFFFFFFF, 0, 0, 1, 4'h9);
    drain();
    clock_now = 1000;
    foreach (phase_limits[p]) begin
      write_limit(5'(phase_limits[p]));
      if (p == 4) calm = 1'b1;
      for (int k = 0; k < 96; k++) begin
        logic m;
        m = ($urandom_range(0, 99) < 55) ? 1'b0 : 1'b1;
        case ($urandom_range(0, 9))
          0: clock_now = clock_now - $urandom_range(0, 3);
          1: clock_now = $urandom();
          default: clock_now = clock_now + $urandom_range(0, 3);
        endcase
        add(m, clock_now, 20'($urandom()),
            ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 2048)),
            1'($urandom()), 4'($urandom()));
        if (k == 40 && p == 1) begin
          // pause the sender until the block has caught up
          while (pending_q.size() > 0 || in_tvalid) @(posedge clk);
          hold_tx = 1'b1;
          while (results_q.size() > 0) @(posedge clk);
          hold_tx = 1'b0;
        end
      end
      drain();
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
